### design/rtc_time_field_converter_unit_macros.svh
// Assertion helpers for the RTC field converter.
// Each macro expects clk and arst_n in scope.
`ifndef RTC_TIME_FIELD_CONVERTER_UNIT_MACROS_SVH
`define RTC_TIME_FIELD_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define RTCFC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside of reset.
`define RTCFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/rtcfc_pkg.sv
`default_nettype none
package rtcfc_pkg;

	// Configuration register indexes.
	typedef enum logic [3:0] {
		CFG_BINARY_MODE  = 4'd0,
		CFG_HOUR_24_MODE = 4'd1
	} cfg_index_t;

	typedef enum logic {
		OP_DECODE = 1'b0,
		OP_ENCODE = 1'b1
	} conv_op_t;

	localparam logic [7:0]  HOUR_NOON    = 8'd12;
	localparam logic [7:0]  HOUR_MAX     = 8'd23;
	localparam logic [7:0]  MINSEC_MAX   = 8'd59;
	localparam logic [7:0]  DAY_MIN      = 8'd1;
	localparam logic [7:0]  DAY_MAX      = 8'd31;
	localparam logic [7:0]  MONTH_MIN    = 8'd1;
	localparam logic [7:0]  MONTH_MAX    = 8'd12;
	localparam logic [11:0] YEAR_BASE    = 12'd2000;
	localparam logic [11:0] YEAR_LAST    = 12'd2099;
	localparam logic [11:0] DOS_EPOCH    = 12'd1980;
	localparam logic [6:0]  DOS_YEAR_OFS = 7'(YEAR_BASE - DOS_EPOCH);

	typedef struct packed {
		logic [7:0]  sec;
		logic [7:0]  min;
		logic [7:0]  hour;
		logic [7:0]  day;
		logic [7:0]  month;
		logic [11:0] year;
		logic [31:0] dos;
		logic        err;
	} conv_result_t;

	// High nibble times ten plus low nibble; invalid digits pass through unchecked.
	function automatic logic [7:0] bcd2bin(input logic [7:0] b);
		bcd2bin = 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
	endfunction

	// Two BCD digits for values up to 99; tens come from a multiply by 205/2048.
	function automatic logic [7:0] bin2bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  rem;
		prod = 15'(v) * 15'd205;
		tens = prod[14:11];
		rem  = v - (7'({tens, 3'b000}) + 7'({tens, 1'b0}));
		bin2bcd = {tens, rem[3:0]};
	endfunction

endpackage
`default_nettype wire

### design/rtcfc_decode.sv
`default_nettype none
module rtcfc_decode (
	input  wire logic                      binary_mode,
	input  wire logic                      hour_24_mode,
	input  wire logic [7:0]                sec_in,
	input  wire logic [7:0]                min_in,
	input  wire logic [7:0]                hour_in,
	input  wire logic [7:0]                day_in,
	input  wire logic [7:0]                month_in,
	input  wire logic [11:0]               year_in,
	output rtcfc_pkg::conv_result_t        res
);
	import rtcfc_pkg::*;

	logic       pm;
	logic [7:0] h_raw;
	logic [7:0] s_v, m_v, h_v, d_v, mo_v, yr_v;
	logic [7:0] h_noon, h_fin;
	logic [6:0] dos_year;

	assign pm    = hour_in[7];
	assign h_raw = {1'b0, hour_in[6:0]};

	assign s_v  = binary_mode ? sec_in        : bcd2bin(sec_in);
	assign m_v  = binary_mode ? min_in        : bcd2bin(min_in);
	assign h_v  = binary_mode ? h_raw         : bcd2bin(h_raw);
	assign d_v  = binary_mode ? day_in        : bcd2bin(day_in);
	assign mo_v = binary_mode ? month_in      : bcd2bin(month_in);
	assign yr_v = binary_mode ? year_in[7:0]  : bcd2bin(year_in[7:0]);

	// Twelve o'clock is hour zero of its half day; PM then adds twelve.
	assign h_noon = (h_v == HOUR_NOON) ? 8'd0 : h_v;
	assign h_fin  = hour_24_mode ? h_v : (pm ? h_noon + HOUR_NOON : h_noon);

	assign dos_year = DOS_YEAR_OFS + yr_v[6:0];

	always_comb begin
		res.sec   = s_v;
		res.min   = m_v;
		res.hour  = h_fin;
		res.day   = d_v;
		res.month = mo_v;
		res.year  = YEAR_BASE + {4'b0000, yr_v};
		res.dos   = {dos_year, mo_v[3:0], d_v[4:0], h_fin[4:0], m_v[5:0], s_v[5:1]};
		res.err   = 1'b0;
	end

endmodule
`default_nettype wire

### design/rtcfc_encode.sv
`default_nettype none
module rtcfc_encode (
	input  wire logic                      binary_mode,
	input  wire logic                      hour_24_mode,
	input  wire logic [7:0]                sec_in,
	input  wire logic [7:0]                min_in,
	input  wire logic [7:0]                hour_in,
	input  wire logic [7:0]                day_in,
	input  wire logic [7:0]                month_in,
	input  wire logic [11:0]               year_in,
	output rtcfc_pkg::conv_result_t        res
);
	import rtcfc_pkg::*;

	logic       bad;
	logic       pm;
	logic [4:0] h_mod, h_12;
	logic [4:0] hh;
	logic [6:0] yb;
	logic [7:0] s_b, m_b, h_b, d_b, mo_b, y_b;

	assign bad = (hour_in > HOUR_MAX) || (min_in > MINSEC_MAX) || (sec_in > MINSEC_MAX) ||
		(day_in < DAY_MIN) || (day_in > DAY_MAX) ||
		(month_in < MONTH_MIN) || (month_in > MONTH_MAX) ||
		(year_in < YEAR_BASE) || (year_in > YEAR_LAST);

	// In range, the hour fits in five bits; in 12-hour mode midnight and noon show as twelve.
	assign pm    = (hour_in >= HOUR_NOON);
	assign h_mod = pm ? hour_in[4:0] - HOUR_NOON[4:0] : hour_in[4:0];
	assign h_12  = (h_mod == 5'd0) ? HOUR_NOON[4:0] : h_mod;
	assign hh    = hour_24_mode ? hour_in[4:0] : h_12;

	assign yb = 7'(year_in - YEAR_BASE);

	assign s_b  = binary_mode ? {1'b0, sec_in[6:0]}   : bin2bcd(sec_in[6:0]);
	assign m_b  = binary_mode ? {1'b0, min_in[6:0]}   : bin2bcd(min_in[6:0]);
	assign h_b  = binary_mode ? {3'b000, hh}          : bin2bcd({2'b00, hh});
	assign d_b  = binary_mode ? {1'b0, day_in[6:0]}   : bin2bcd(day_in[6:0]);
	assign mo_b = binary_mode ? {1'b0, month_in[6:0]} : bin2bcd(month_in[6:0]);
	assign y_b  = binary_mode ? {1'b0, yb}            : bin2bcd(yb);

	always_comb begin
		res = '0;
		if (bad) begin
			res.err = 1'b1;
		end else begin
			res.sec   = s_b;
			res.min   = m_b;
			res.hour  = {pm & ~hour_24_mode, h_b[6:0]};
			res.day   = d_b;
			res.month = mo_b;
			res.year  = {4'b0000, y_b};
		end
	end

endmodule
`default_nettype wire

### design/rtc_time_field_converter_unit.sv
`default_nettype none
// RTC time field converter. Pulse start with the fields of one item and the
// converted item appears on the result ports, marked by a single-cycle done
// strobe. A new item may be started in every cycle, so throughput is one item
// per clock and busy never rises. On its way each item is held first in the
// input register and then in the result register, which together bracket
// the conversion logic. The receiver cannot stall: each result is present for
// exactly one cycle and must be captured then. Configuration writes
// (binary_mode at index 0, hour_24_mode at index 1) are always accepted and
// should only be made while no item is in flight. In decode mode the hour's
// PM bit is stripped, BCD is undone unless binary mode is set, and 12-hour
// time is mapped to 24-hour time unless 24-hour mode is set; the year comes
// out as 2000 plus the year byte and dos_stamp carries the packed DOS date
// (high half) and time (low half). In encode mode out-of-range fields raise
// range_error and zero all other results.
module rtc_time_field_converter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Item command channel.
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [7:0]  sec_in,
	input  wire logic [7:0]  min_in,
	input  wire logic [7:0]  hour_in,
	input  wire logic [7:0]  day_in,
	input  wire logic [7:0]  month_in,
	input  wire logic [11:0] year_in,
	// Result channel.
	output logic             done,
	output logic [7:0]       sec_out,
	output logic [7:0]       min_out,
	output logic [7:0]       hour_out,
	output logic [7:0]       day_out,
	output logic [7:0]       month_out,
	output logic [11:0]      year_out,
	output logic [31:0]      dos_stamp,
	output logic             range_error,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic        cfg_data
);
	import rtcfc_pkg::*;

`include "rtc_time_field_converter_unit_macros.svh"

	// Configuration registers.
	logic binary_mode_q;
	logic hour_24_mode_q;

	// Input register stage.
	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  sec_s1, min_s1, hour_s1, day_s1, month_s1;
	logic [11:0] year_s1;

	// Result register stage.
	logic         valid_s2;
	conv_result_t res_s2;

	conv_result_t dec_res, enc_res, sel_res;

	// Every cycle can take an item and every write is taken at once.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			binary_mode_q  <= 1'b0;
			hour_24_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_BINARY_MODE:  binary_mode_q  <= cfg_data;
				CFG_HOUR_24_MODE: hour_24_mode_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Only the valid flag needs a reset; the fields follow it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1    <= op;
			sec_s1   <= sec_in;
			min_s1   <= min_in;
			hour_s1  <= hour_in;
			day_s1   <= day_in;
			month_s1 <= month_in;
			year_s1  <= year_in;
		end
	end

	rtcfc_decode u_decode (
		.binary_mode  (binary_mode_q),
		.hour_24_mode (hour_24_mode_q),
		.sec_in       (sec_s1),
		.min_in       (min_s1),
		.hour_in      (hour_s1),
		.day_in       (day_s1),
		.month_in     (month_s1),
		.year_in      (year_s1),
		.res          (dec_res)
	);

	rtcfc_encode u_encode (
		.binary_mode  (binary_mode_q),
		.hour_24_mode (hour_24_mode_q),
		.sec_in       (sec_s1),
		.min_in       (min_s1),
		.hour_in      (hour_s1),
		.day_in       (day_s1),
		.month_in     (month_s1),
		.year_in      (year_s1),
		.res          (enc_res)
	);

	assign sel_res = (conv_op_t'(op_s1) == OP_ENCODE) ? enc_res : dec_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= sel_res;
		end
	end

	assign done        = valid_s2;
	assign sec_out     = res_s2.sec;
	assign min_out     = res_s2.min;
	assign hour_out    = res_s2.hour;
	assign day_out     = res_s2.day;
	assign month_out   = res_s2.month;
	assign year_out    = res_s2.year;
	assign dos_stamp   = res_s2.dos;
	assign range_error = res_s2.err;

	// An accepted item always reaches the conversion stage next cycle.
	`RTCFC_ASSERT_NEXT(a_start_to_s1, start && !busy, valid_s1, "accepted item lost before stage 1")
	// Every item in the conversion stage produces exactly one result strobe.
	`RTCFC_ASSERT_NEXT(a_s1_to_done, valid_s1, done, "item in stage 1 gave no result")
	// A range error zeroes every other result field.
	`RTCFC_ASSERT_IMPL(a_err_zero, done && range_error, (dos_stamp == 32'd0) && (year_out == 12'd0) && (hour_out == 8'd0) && (sec_out == 8'd0), "range error with nonzero fields")

endmodule
`default_nettype wire

### bench/rtc_time_field_converter_checker.sv
`timescale 1ns / 100ps
// Watches the item, result and configuration channels of the RTC field converter.
// It predicts every accepted item and compares the results in order.
module rtc_time_field_converter_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        op,
	input  logic [7:0]  sec_in,
	input  logic [7:0]  min_in,
	input  logic [7:0]  hour_in,
	input  logic [7:0]  day_in,
	input  logic [7:0]  month_in,
	input  logic [11:0] year_in,
	input  logic        done,
	input  logic [7:0]  sec_out,
	input  logic [7:0]  min_out,
	input  logic [7:0]  hour_out,
	input  logic [7:0]  day_out,
	input  logic [7:0]  month_out,
	input  logic [11:0] year_out,
	input  logic [31:0] dos_stamp,
	input  logic        range_error,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic        cfg_data,
	output int          fail_count,
	output int          pending,
	output int          decoded_count,
	output int          encoded_count,
	output int          rejected_count
);
	import rtcfc_pkg::*;

	logic         binary_mode  = 1'b0;
	logic         hour_24_mode = 1'b0;
	conv_result_t expected_q[$];
	conv_result_t want;

	initial begin
		fail_count = 0;
		pending = 0;
		decoded_count = 0;
		encoded_count = 0;
		rejected_count = 0;
	end

	function automatic int bcd_value(input logic [7:0] b);
		return b[7:4] * 10 + b[3:0];
	endfunction

	function automatic logic [7:0] bcd_byte(input int v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	// Expected conversion of one item under the given mode bits.
	function automatic conv_result_t convert_item(input conv_op_t kind,
			input logic [7:0] s_b, input logic [7:0] m_b, input logic [7:0] h_b,
			input logic [7:0] d_b, input logic [7:0] mo_b, input logic [11:0] y_w,
			input logic bin, input logic h24);
		conv_result_t r;
		int s, m, h, d, mo, y, yr, hh, dos_date, dos_time;
		logic pm;
		r = '0;
		s = int'(s_b);
		m = int'(m_b);
		h = int'(h_b);
		d = int'(d_b);
		mo = int'(mo_b);
		y = int'(y_w);
		if (kind == OP_DECODE) begin
			pm = h_b[7];
			h = int'(h_b[6:0]);
			yr = int'(y_w[7:0]);
			if (!bin) begin
				s = bcd_value(s_b);
				m = bcd_value(m_b);
				h = bcd_value({1'b0, h_b[6:0]});
				d = bcd_value(d_b);
				mo = bcd_value(mo_b);
				yr = bcd_value(y_w[7:0]);
			end
			if (!h24) begin
				if (h == HOUR_NOON)
					h = 0;
				if (pm)
					h = h + int'(HOUR_NOON);
			end
			y = YEAR_BASE + yr;
			dos_date = (((y - DOS_EPOCH) & 'h7F) << 9) | ((mo & 'hF) << 5) | (d & 'h1F);
			dos_time = ((h & 'h1F) << 11) | ((m & 'h3F) << 5) | ((s >> 1) & 'h1F);
			r.sec = 8'(s);
			r.min = 8'(m);
			r.hour = 8'(h);
			r.day = 8'(d);
			r.month = 8'(mo);
			r.year = 12'(y);
			r.dos = {16'(dos_date), 16'(dos_time)};
		end else if (h > HOUR_MAX || m > MINSEC_MAX || s > MINSEC_MAX || d < DAY_MIN ||
				d > DAY_MAX || mo < MONTH_MIN || mo > MONTH_MAX || y < YEAR_BASE ||
				y > YEAR_LAST) begin
			r.err = 1'b1;
		end else begin
			pm = 1'b0;
			hh = h;
			if (!h24) begin
				pm = (h >= HOUR_NOON);
				hh = h % HOUR_NOON;
				if (hh == 0)
					hh = int'(HOUR_NOON);
			end
			yr = y - YEAR_BASE;
			if (bin) begin
				r.sec = 8'(s);
				r.min = 8'(m);
				r.hour = 8'(hh);
				r.day = 8'(d);
				r.month = 8'(mo);
				r.year = 12'(yr);
			end else begin
				r.sec = bcd_byte(s);
				r.min = bcd_byte(m);
				r.hour = bcd_byte(hh);
				r.day = bcd_byte(d);
				r.month = bcd_byte(mo);
				r.year = 12'(bcd_byte(yr));
			end
			r.hour[7] = pm;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			binary_mode = 1'b0;
			hour_24_mode = 1'b0;
			expected_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					CFG_BINARY_MODE: binary_mode = cfg_data;
					CFG_HOUR_24_MODE: hour_24_mode = cfg_data;
					default: ;
				endcase
			end
			if (done) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					$error("result strobe with no item outstanding");
				end else begin
					want = expected_q.pop_front();
					check_field("sec_out", 32'(want.sec), 32'(sec_out));
					check_field("min_out", 32'(want.min), 32'(min_out));
					check_field("hour_out", 32'(want.hour), 32'(hour_out));
					check_field("day_out", 32'(want.day), 32'(day_out));
					check_field("month_out", 32'(want.month), 32'(month_out));
					check_field("year_out", 32'(want.year), 32'(year_out));
					check_field("dos_stamp", want.dos, dos_stamp);
					check_field("range_error", 32'(want.err), 32'(range_error));
					if (want.err)
						rejected_count++;
				end
			end
			if (start && !busy) begin
				expected_q.push_back(convert_item(conv_op_t'(op), sec_in, min_in, hour_in,
					day_in, month_in, year_in, binary_mode, hour_24_mode));
				if (conv_op_t'(op) == OP_DECODE)
					decoded_count++;
				else
					encoded_count++;
			end
			pending = expected_q.size();
		end
	end

endmodule

### bench/tb_rtc_time_field_converter_unit.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the RTC field converter. The checker beside the
// block predicts and compares every result; this module only drives items and
// configuration writes and reports the outcome.
module tb_rtc_time_field_converter_unit;
	import rtcfc_pkg::*;

	// The run is stopped here if it hangs; a correct run needs far fewer cycles.
	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEMS_PER_PHASE = 340;

	typedef struct packed {
		conv_op_t    kind;
		logic [7:0]  sec;
		logic [7:0]  minute;
		logic [7:0]  hour;
		logic [7:0]  day;
		logic [7:0]  month;
		logic [11:0] year;
	} rtc_item_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        op;
	logic [7:0]  sec_in;
	logic [7:0]  min_in;
	logic [7:0]  hour_in;
	logic [7:0]  day_in;
	logic [7:0]  month_in;
	logic [11:0] year_in;
	logic        done;
	logic [7:0]  sec_out;
	logic [7:0]  min_out;
	logic [7:0]  hour_out;
	logic [7:0]  day_out;
	logic [7:0]  month_out;
	logic [11:0] year_out;
	logic [31:0] dos_stamp;
	logic        range_error;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic        cfg_data;

	int fail_count;
	int pending;
	int decoded_count;
	int encoded_count;
	int rejected_count;
	int cycle_count = 0;

	// The mode bits as last written; the random generator uses them to build
	// register bytes that are well formed for the current setting.
	logic bin_mode = 1'b0;
	logic h24_mode = 1'b0;

	// Length of the current stretch of back-to-back items.
	int burst_left = 0;

	rtc_time_field_converter_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.sec_in(sec_in),
		.min_in(min_in),
		.hour_in(hour_in),
		.day_in(day_in),
		.month_in(month_in),
		.year_in(year_in),
		.done(done),
		.sec_out(sec_out),
		.min_out(min_out),
		.hour_out(hour_out),
		.day_out(day_out),
		.month_out(month_out),
		.year_out(year_out),
		.dos_stamp(dos_stamp),
		.range_error(range_error),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rtc_time_field_converter_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.sec_in(sec_in),
		.min_in(min_in),
		.hour_in(hour_in),
		.day_in(day_in),
		.month_in(month_in),
		.year_in(year_in),
		.done(done),
		.sec_out(sec_out),
		.min_out(min_out),
		.hour_out(hour_out),
		.day_out(day_out),
		.month_out(month_out),
		.year_out(year_out),
		.dos_stamp(dos_stamp),
		.range_error(range_error),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending),
		.decoded_count(decoded_count),
		.encoded_count(encoded_count),
		.rejected_count(rejected_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog. A hang anywhere in the run ends here with a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// A value in lo..hi that lands on either end noticeably often.
	function automatic int pick(input int lo, input int hi);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return lo;
		if (r < 30)
			return hi;
		return $urandom_range(lo, hi);
	endfunction

	// Register byte for a value in the current data mode.
	function automatic logic [7:0] reg_byte(input int v);
		if (bin_mode)
			return 8'(v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	function automatic rtc_item_t make_item(input conv_op_t kind, input int s, input int m,
			input int h, input int d, input int mo, input int y);
		rtc_item_t it;
		it.kind = kind;
		it.sec = 8'(s);
		it.minute = 8'(m);
		it.hour = 8'(h);
		it.day = 8'(d);
		it.month = 8'(mo);
		it.year = 12'(y);
		return it;
	endfunction

	function automatic rtc_item_t random_item();
		rtc_item_t it;
		int r;
		int h12;
		r = $urandom_range(0, 99);
		it.kind = $urandom_range(0, 1) ? OP_ENCODE : OP_DECODE;
		// Start from fully random fields; the well-formed cases overwrite them.
		it.sec = 8'($urandom_range(0, 255));
		it.minute = 8'($urandom_range(0, 255));
		it.hour = 8'($urandom_range(0, 255));
		it.day = 8'($urandom_range(0, 255));
		it.month = 8'($urandom_range(0, 255));
		it.year = 12'($urandom_range(0, 4095));
		if (it.kind == OP_ENCODE) begin
			if (r < 90) begin
				it.sec = 8'(pick(0, 59));
				it.minute = 8'(pick(0, 59));
				it.hour = 8'(pick(0, 23));
				it.day = 8'(pick(1, 31));
				it.month = 8'(pick(1, 12));
				it.year = 12'(pick(2000, 2099));
			end
			// Push exactly one field just past its limit.
			if (r >= 75 && r < 90) begin
				case ($urandom_range(0, 8))
					0: it.sec = 8'($urandom_range(60, 61));
					1: it.minute = 8'($urandom_range(60, 61));
					2: it.hour = 8'($urandom_range(24, 25));
					3: it.day = 8'd0;
					4: it.day = 8'd32;
					5: it.month = 8'd0;
					6: it.month = 8'd13;
					7: it.year = 12'd1999;
					default: it.year = 12'd2100;
				endcase
			end
		end else if (r < 70) begin
			// Register bytes as the clock chip would hold them in the current mode.
			it.sec = reg_byte(pick(0, 59));
			it.minute = reg_byte(pick(0, 59));
			it.day = reg_byte(pick(1, 31));
			it.month = reg_byte(pick(1, 12));
			it.year = {4'($urandom_range(0, 15)), reg_byte(pick(0, 99))};
			if (h24_mode) begin
				it.hour = reg_byte(pick(0, 23));
			end else begin
				h12 = pick(1, 12);
				it.hour = reg_byte(h12) | {$urandom_range(0, 1) == 1, 7'b0};
			end
		end
		return it;
	endfunction

	// Present one item and hold it until the block takes it. Start stays high
	// into the next call when no gap follows.
	task automatic send_item(input rtc_item_t it);
		@(negedge clk);
		start = 1'b1;
		op = it.kind;
		sec_in = it.sec;
		min_in = it.minute;
		hour_in = it.hour;
		day_in = it.day;
		month_in = it.month;
		year_in = it.year;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start between items, with noise on the idle item fields.
	task automatic idle_for(input int n);
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			op = 1'($urandom_range(0, 1));
			sec_in = 8'($urandom_range(0, 255));
			min_in = 8'($urandom_range(0, 255));
			hour_in = 8'($urandom_range(0, 255));
			day_in = 8'($urandom_range(0, 255));
			month_in = 8'($urandom_range(0, 255));
			year_in = 12'($urandom_range(0, 4095));
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Mostly short gaps, a few long ones, and now and then a burst with none.
	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst_left = $urandom_range(20, 50);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Stop sending and wait until every outstanding result has come back.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		// Every item produces a result, so a short margin covers the pipeline.
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mode changes only happen with the converter empty.
	task automatic set_modes(input logic bin, input logic h24);
		drain();
		write_reg(CFG_BINARY_MODE, bin);
		write_reg(CFG_HOUR_24_MODE, h24);
		bin_mode = bin;
		h24_mode = h24;
	endtask

	task automatic random_phase();
		int i;
		for (i = 0; i < ITEMS_PER_PHASE; i++) begin
			send_item(random_item());
			idle_for(next_gap());
		end
	endtask

	initial begin
		rtc_item_t directed_q[$];
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_DECODE;
		sec_in = '0;
		min_in = '0;
		hour_in = '0;
		day_in = '0;
		month_in = '0;
		year_in = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BINARY_MODE;
		cfg_data = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items under the reset setting: BCD fields and 12-hour time.
		// Decode covers all-zero and all-ones bytes, noon and midnight in both
		// halves of the day, and the PM bit on top of a maximal hour byte.
		directed_q.push_back(make_item(OP_DECODE, 0, 0, 0, 0, 0, 0));
		directed_q.push_back(make_item(OP_DECODE, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFFF));
		directed_q.push_back(make_item(OP_DECODE, 'h59, 'h59, 'h12, 'h31, 'h12, 'h99));
		directed_q.push_back(make_item(OP_DECODE, 'h00, 'h00, 'h92, 'h01, 'h01, 'h00));
		directed_q.push_back(make_item(OP_DECODE, 'h01, 'h30, 'h81, 'h15, 'h06, 'hF25));
		directed_q.push_back(make_item(OP_DECODE, 'hAA, 'h55, 'h7F, 'hA5, 'h5A, 'h0AA));
		// Encode: both corners of the valid range, the hours around noon and
		// midnight, then each field just outside its range.
		directed_q.push_back(make_item(OP_ENCODE, 0, 0, 0, 1, 1, 2000));
		directed_q.push_back(make_item(OP_ENCODE, 59, 59, 23, 31, 12, 2099));
		directed_q.push_back(make_item(OP_ENCODE, 30, 15, 12, 10, 7, 2050));
		directed_q.push_back(make_item(OP_ENCODE, 30, 15, 11, 10, 7, 2050));
		directed_q.push_back(make_item(OP_ENCODE, 30, 15, 13, 10, 7, 2050));
		directed_q.push_back(make_item(OP_ENCODE, 60, 0, 0, 1, 1, 2000));
		directed_q.push_back(make_item(OP_ENCODE, 0, 60, 0, 1, 1, 2000));
		directed_q.push_back(make_item(OP_ENCODE, 0, 0, 24, 1, 1, 2000));
		directed_q.push_back(make_item(OP_ENCODE, 0, 0, 0, 0, 1, 2000));
		directed_q.push_back(make_item(OP_ENCODE, 0, 0, 0, 32, 1, 2000));
		directed_q.push_back(make_item(OP_ENCODE, 0, 0, 0, 1, 0, 2000));
		directed_q.push_back(make_item(OP_ENCODE, 0, 0, 0, 1, 13, 2000));
		directed_q.push_back(make_item(OP_ENCODE, 0, 0, 0, 1, 1, 1999));
		directed_q.push_back(make_item(OP_ENCODE, 0, 0, 0, 1, 1, 2100));
		directed_q.push_back(make_item(OP_ENCODE, 255, 255, 255, 255, 255, 4095));
		foreach (directed_q[k])
			send_item(directed_q[k]);

		// Random items under each mode setting, including a return to the
		// reset setting after both bits have been set and cleared.
		random_phase();
		set_modes(1'b1, 1'b1);
		random_phase();
		set_modes(1'b1, 1'b0);
		random_phase();
		set_modes(1'b0, 1'b1);
		random_phase();
		set_modes(1'b0, 1'b0);
		random_phase();

		// Let the last results come home, plus a margin for strays.
		drain();
		repeat (8) @(negedge clk);

		$display("Covered %0d decode and %0d encode items across four mode settings,",
			decoded_count, encoded_count);
		$display("%0d of them rejected as out of range; %0d mismatches.",
			rejected_count, fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### rtc_time_field_converter_unit.f
+incdir+design
design/rtcfc_pkg.sv
design/rtcfc_decode.sv
design/rtcfc_encode.sv
design/rtc_time_field_converter_unit.sv
bench/rtc_time_field_converter_checker.sv
bench/tb_rtc_time_field_converter_unit.sv
